>>> hw/rtl/pib_pkg.sv
`timescale 1ns / 1ps

package pib_pkg;

    // Configuration register index
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_CENTER_X      = 3'd0;
    localparam t_cfg_idx REG_CENTER_Y      = 3'd1;
    localparam t_cfg_idx REG_CENTER_Z      = 3'd2;
    localparam t_cfg_idx REG_BOX_HEADING   = 3'd3;
    localparam t_cfg_idx REG_HALF_EXTENT_X = 3'd4;
    localparam t_cfg_idx REG_HALF_EXTENT_Y = 3'd5;
    localparam t_cfg_idx REG_HALF_EXTENT_Z = 3'd6;

    // Full turn in radians, used to fill the sine table
    localparam real TWO_PI = 2.0 * 3.14159265358979323846;

endpackage

>>> hw/rtl/pib_trig.sv
`timescale 1ns / 1ps

// Sine/cosine holder: looks up both values for a rotation index in a
// registered sine ROM, one read per cycle, and keeps them until the next load.
module pib_trig
    import pib_pkg::*;
#(
    parameter int ANGLE_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [ANGLE_BITS-1:0]            i_angle,
    output logic                             o_busy,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos
);

    localparam int TW          = TRIG_FRAC_BITS + 2;
    localparam int ANGLE_COUNT = 1 << ANGLE_BITS;
    localparam real SCALE      = 2.0 ** TRIG_FRAC_BITS;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(ANGLE_COUNT / 4);
    localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) << TRIG_FRAC_BITS;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SIN  = 2'd1;
    localparam logic [1:0] PH_COS  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    typedef logic signed [TW-1:0] t_trig;
    typedef t_trig t_rom [ANGLE_COUNT];

    // Round half away from zero of sin(2*pi*k/N) scaled to Q1.F
    function automatic t_rom build_rom();
        t_rom tab;
        real  v;
        for (int k = 0; k < ANGLE_COUNT; k++) begin
            v = $sin(TWO_PI * k / ANGLE_COUNT) * SCALE;
            if (v >= 0.0) begin
                tab[k] = TW'($rtoi(v + 0.5));
            end else begin
                tab[k] = TW'(-$rtoi(0.5 - v));
            end
        end
        return tab;
    endfunction

    localparam t_rom TRIG_ROM = build_rom();

    logic [1:0]            r_phase;
    logic [ANGLE_BITS-1:0] r_rot;
    logic [ANGLE_BITS-1:0] rom_addr;
    t_trig                 r_rom_q;
    t_trig                 r_sin;
    t_trig                 r_cos;

    // Sine entry first, then the entry a quarter turn later
    assign rom_addr = (r_phase == PH_SIN) ? r_rot : r_rot + QUARTER;

    always_ff @(posedge i_clk) begin
        r_rom_q <= TRIG_ROM[rom_addr];
    end

    // Step through the two reads and capture the results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rot   <= '0;
            r_sin   <= '0;
            r_cos   <= TRIG_ONE;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_load) begin
                        r_rot   <= i_angle;
                        r_phase <= PH_SIN;
                    end
                end
                PH_SIN: begin
                    r_phase <= PH_COS;
                end
                PH_COS: begin
                    r_sin   <= r_rom_q;
                    r_phase <= PH_DONE;
                end
                PH_DONE: begin
                    r_cos   <= r_rom_q;
                    r_phase <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_busy = (r_phase != PH_IDLE);
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

>>> hw/rtl/point_in_oriented_box_top.sv
`timescale 1ns / 1ps

// Point-in-oriented-box filter. Each streamed point (signed coordinates in
// 1/64 units) is offset from the configured box center, its horizontal part
// is rotated into the box frame by the configured heading (4096ths of a turn,
// counterclockwise) and every axis is checked, inclusively, against its
// half-extent; the result is one bit per point. The block takes one point per
// cycle unless the output stalls; each point passes through an input
// register, a register after the four rotation multipliers and the result
// register. Writing box_heading starts a lookup of sine and cosine in the
// sine ROM, one ROM read per cycle; while that lookup runs neither points
// nor further configuration writes are accepted. Other registers take effect
// at once. Write configuration only while no point is in flight.
module point_in_oriented_box_top
    import pib_pkg::*;
#(
    parameter int COORD_BITS     = 22,
    parameter int ANGLE_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // stream in
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // tdata: point_x, point_y, point_z, zero fill
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]           i_s_tdata,
    // stream out
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // tdata: inside_res, zero fill
    output logic [7:0]                                  o_m_tdata,
    // configuration write
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                        i_cfg_index,
    input  logic [COORD_BITS-1:0]                       i_cfg_data
);

    localparam int C  = COORD_BITS;
    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;      // trig value, Q1.F signed
    localparam int DW = C + 1;      // offset from center
    localparam int ZW = DW + 1;     // vertical compare width
    localparam int PW = DW + TW;    // one product
    localparam int SW = PW + 1;     // sum of two products
    localparam int LW = SW - F;     // local coordinate after the shift

    // Configuration registers
    logic signed [C-1:0] r_cx, r_cy, r_cz;
    logic [C-2:0]        r_hx, r_hy, r_hz;

    logic                cfg_fire;
    logic                trig_load;
    logic [ANGLE_BITS-1:0] rot_angle;
    logic                trig_busy;
    logic signed [TW-1:0] rot_sin, rot_cos;

    assign o_cfg_ready = !trig_busy;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign trig_load   = cfg_fire && (i_cfg_index == REG_BOX_HEADING);
    assign rot_angle   = ANGLE_BITS'(0) - i_cfg_data[ANGLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
            r_hx <= '0;
            r_hy <= '0;
            r_hz <= '0;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_CENTER_X:      r_cx <= i_cfg_data;
                REG_CENTER_Y:      r_cy <= i_cfg_data;
                REG_CENTER_Z:      r_cz <= i_cfg_data;
                REG_HALF_EXTENT_X: r_hx <= i_cfg_data[C-2:0];
                REG_HALF_EXTENT_Y: r_hy <= i_cfg_data[C-2:0];
                REG_HALF_EXTENT_Z: r_hz <= i_cfg_data[C-2:0];
                default: ;  // heading goes to the trig unit, others dropped
            endcase
        end
    end

    pib_trig #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (trig_load),
        .i_angle (rot_angle),
        .o_busy  (trig_busy),
        .o_sin   (rot_sin),
        .o_cos   (rot_cos)
    );

    // Pipeline flow control
    logic r_v1, r_v2, r_v3;
    logic take3, ready2, ready1, in_fire;

    assign take3      = !r_v3 || i_m_tready;
    assign ready2     = !r_v2 || take3;
    assign ready1     = !r_v1 || ready2;
    assign o_s_tready = ready1 && !trig_busy;
    assign in_fire    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) r_v1 <= in_fire;
            if (ready2) r_v2 <= r_v1;
            if (take3)  r_v3 <= r_v2;
        end
    end

    // Stage 1: input register
    logic signed [C-1:0] r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_px <= i_s_tdata[C-1:0];
            r_py <= i_s_tdata[2*C-1:C];
            r_pz <= i_s_tdata[3*C-1:2*C];
        end
    end

    // Stage 2: offsets, rotation products and the vertical check
    logic signed [DW-1:0] dx, dy, dz;
    logic signed [ZW-1:0] dz_w, hz_w;
    logic signed [PW-1:0] n_xc, n_ys, n_yc, n_xs;
    logic signed [PW-1:0] r_xc, r_ys, r_yc, r_xs;
    logic                 n_in_z, r_in_z;

    always_comb begin
        dx     = $signed({r_px[C-1], r_px}) - $signed({r_cx[C-1], r_cx});
        dy     = $signed({r_py[C-1], r_py}) - $signed({r_cy[C-1], r_cy});
        dz     = $signed({r_pz[C-1], r_pz}) - $signed({r_cz[C-1], r_cz});
        n_xc   = dx * rot_cos;
        n_ys   = dy * rot_sin;
        n_yc   = dy * rot_cos;
        n_xs   = dx * rot_sin;
        dz_w   = $signed({dz[DW-1], dz});
        hz_w   = $signed({{(ZW-C+1){1'b0}}, r_hz});
        n_in_z = (dz_w <= hz_w) && (dz_w >= -hz_w);
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_xc   <= n_xc;
            r_ys   <= n_ys;
            r_yc   <= n_yc;
            r_xs   <= n_xs;
            r_in_z <= n_in_z;
        end
    end

    // Stage 3: sum, floor shift, horizontal checks into the result register
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [LW-1:0] lx, ly, hx_w, hy_w;
    logic                 n_inside, r_inside;

    always_comb begin
        sum_x    = $signed({r_xc[PW-1], r_xc}) - $signed({r_ys[PW-1], r_ys});
        sum_y    = $signed({r_yc[PW-1], r_yc}) + $signed({r_xs[PW-1], r_xs});
        lx       = sum_x[SW-1:F];
        ly       = sum_y[SW-1:F];
        hx_w     = $signed({{(LW-C+1){1'b0}}, r_hx});
        hy_w     = $signed({{(LW-C+1){1'b0}}, r_hy});
        n_inside = r_in_z
                && (lx <= hx_w) && (lx >= -hx_w)
                && (ly <= hy_w) && (ly >= -hy_w);
    end

    always_ff @(posedge i_clk) begin
        if (take3 && r_v2) begin
            r_inside <= n_inside;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {7'b0, r_inside};

    // A heading write always occupies the trig unit on the next cycle
    a_heading_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig_load |=> trig_busy)
        else $error("heading write did not start trig lookup");

    // No point enters while configuration is blocked
    a_cfg_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> !o_s_tready)
        else $error("point accepted during trig lookup");

    // An accepted point lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_v1)
        else $error("accepted point lost at input register");

    // A product stage that cannot advance keeps its item
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !take3) |=> (r_v2 && $stable(r_xc) && $stable(r_in_z)))
        else $error("product stage dropped an item under stall");

endmodule

>>> verif/point_in_oriented_box_top_test.sv
`timescale 1ns / 1ps

module point_in_oriented_box_top_test;
    import pib_pkg::*;

    localparam int COORD_W     = 22;
    localparam int FRAC_SHIFT  = 15;
    localparam int USE_MODEL   = -1;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 142;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;
    localparam t_cfg_idx REG_UNUSED = 3'd7;

    localparam logic [COORD_W-1:0] C_MIN = 22'h200000;
    localparam logic [COORD_W-1:0] C_MAX = 22'h1FFFFF;
    localparam logic [COORD_W-1:0] C_M1  = 22'h3FFFFF;

    typedef enum logic {ROW_CFG, ROW_POINT} t_row_kind;

    // For ROW_CFG, field a carries the write data
    typedef struct {
        t_row_kind          kind;
        t_cfg_idx           idx;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic [COORD_W-1:0] c;
        int                 want;
    } t_stim_row;

    localparam int N_ROWS = 37;

    t_stim_row dir_rows [N_ROWS] = '{
        // zero extents after reset: only the exact center passes
        '{ROW_POINT, REG_CENTER_X, 22'd0, 22'd0, 22'd0, 1},
        '{ROW_POINT, REG_CENTER_X, 22'd1, 22'd0, 22'd0, 0},
        '{ROW_POINT, REG_CENTER_X, 22'd0, C_M1, 22'd0, 0},
        '{ROW_POINT, REG_CENTER_X, 22'd0, 22'd0, C_M1, 0},
        // widest box, extent y written with the masked top bit set
        '{ROW_CFG, REG_HALF_EXTENT_X, C_MAX, 22'd0, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_HALF_EXTENT_Y, C_M1, 22'd0, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_HALF_EXTENT_Z, C_MAX, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, C_MAX, C_MAX, C_MAX, 1},
        '{ROW_POINT, REG_CENTER_X, C_MIN, 22'd0, 22'd0, 0},
        '{ROW_POINT, REG_CENTER_X, 22'd0, 22'd0, C_MIN, 0},
        '{ROW_POINT, REG_CENTER_X, 22'h200001, 22'h200001, 22'h200001, 1},
        // most negative center: largest offsets
        '{ROW_CFG, REG_CENTER_X, C_MIN, 22'd0, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_CENTER_Y, C_MIN, 22'd0, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_CENTER_Z, C_MIN, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, C_MAX, 22'd0, 22'd0, 0},
        '{ROW_POINT, REG_CENTER_X, C_M1, C_M1, C_M1, 1},
        '{ROW_POINT, REG_CENTER_X, 22'd0, C_M1, C_M1, 0},
        '{ROW_CFG, REG_CENTER_X, 22'd0, 22'd0, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_CENTER_Y, 22'd0, 22'd0, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_CENTER_Z, 22'd0, 22'd0, 22'd0, USE_MODEL},
        // headings: quarter turn, last step (masked write), half turn, eighth
        '{ROW_CFG, REG_BOX_HEADING, 22'd1024, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, 22'h000100, 22'h3FFE00, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, C_MIN, C_MAX, C_MIN, USE_MODEL},
        '{ROW_CFG, REG_BOX_HEADING, C_M1, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, C_MAX, C_MIN, 22'd5, USE_MODEL},
        '{ROW_CFG, REG_BOX_HEADING, 22'd2048, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, 22'h001234, 22'h3ABCDE, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_BOX_HEADING, 22'd512, 22'd0, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_HALF_EXTENT_X, 22'h200005, 22'd0, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_HALF_EXTENT_Y, 22'h000007, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, 22'd7, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, 22'd3, 22'd3, 22'd0, USE_MODEL},
        // write to an unknown index must change nothing
        '{ROW_CFG, REG_UNUSED, 22'h155555, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, 22'd3, 22'd3, 22'd0, USE_MODEL},
        '{ROW_CFG, REG_HALF_EXTENT_Z, 22'd0, 22'd0, 22'd0, USE_MODEL},
        '{ROW_POINT, REG_CENTER_X, 22'd0, 22'd0, 22'd1, 0},
        '{ROW_POINT, REG_CENTER_X, 22'd0, 22'd0, 22'd0, 1}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [71:0]          i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [7:0]           o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0]   i_cfg_data  = '0;

    // Predictor copy of the box configuration
    longint      ctr_x, ctr_y, ctr_z;
    longint      ext_x, ext_y, ext_z;
    longint      rot_sin, rot_cos;
    logic [11:0] heading_q;

    logic        inside_q [$];
    int          mismatch_count = 0;
    bit          hold_off_req   = 1'b0;
    bit          recv_idling    = 1'b1;
    bit          sender_gaps    = 1'b1;

    point_in_oriented_box_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        // tdata: point_x, point_y, point_z, zero fill
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        // tdata: inside_res, zero fill
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // (a * b) >> 62 in Q62
    function automatic longint unsigned q62_mul(input longint unsigned a,
                                                input longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Angle of m steps of a 4096th turn, Q62, m up to an eighth turn
    function automatic longint unsigned step_angle_q62(input longint unsigned m);
        longint unsigned pi_q60;
        longint unsigned ph;
        longint unsigned pl;
        pi_q60 = 64'h3243F6A8885A308D;
        ph = pi_q60 >> 32;
        pl = pi_q60 & 64'hFFFFFFFF;
        return ((ph * m) << 23) + ((pl * m) >> 9);
    endfunction

    // Taylor series of sine or cosine on [0, pi/4], Q62
    function automatic longint unsigned taylor_q62(input longint unsigned m,
                                                   input bit want_cos);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned k;
        x    = step_angle_q62(m);
        x2   = q62_mul(x, x);
        term = want_cos ? (64'd1 << 62) : x;
        sum  = term;
        k    = want_cos ? 64'd0 : 64'd1;
        for (int i = 1; i <= 12; i++) begin
            term = q62_mul(term, x2) / ((k + 1) * (k + 2));
            k += 2;
            if (i % 2 == 1) sum -= term;
            else            sum += term;
        end
        return sum;
    endfunction

    // Q1.15 sine at step k, rounded half away from zero by quadrant folding
    function automatic longint sine_q15(input logic [11:0] k);
        logic [1:0]      quad;
        logic [9:0]      r;
        longint unsigned v;
        longint          mag;
        quad = k[11:10];
        r    = k[9:0];
        if (r <= 10'd512) v = taylor_q62(64'(r), quad[0]);
        else              v = taylor_q62(64'd1024 - 64'(r), !quad[0]);
        mag = longint'((v + (64'd1 << 46)) >> 47);
        return (quad >= 2'd2) ? -mag : mag;
    endfunction

    function automatic void reload_rotation();
        logic [11:0] r;
        r       = 12'd0 - heading_q;
        rot_sin = sine_q15(r);
        rot_cos = sine_q15(r + 12'd1024);
    endfunction

    function automatic void apply_cfg(input t_cfg_idx idx, input logic [COORD_W-1:0] data);
        case (idx)
            REG_CENTER_X:      ctr_x = longint'($signed(data));
            REG_CENTER_Y:      ctr_y = longint'($signed(data));
            REG_CENTER_Z:      ctr_z = longint'($signed(data));
            REG_BOX_HEADING: begin
                heading_q = data[11:0];
                reload_rotation();
            end
            REG_HALF_EXTENT_X: ext_x = longint'(data[20:0]);
            REG_HALF_EXTENT_Y: ext_y = longint'(data[20:0]);
            REG_HALF_EXTENT_Z: ext_z = longint'(data[20:0]);
            default: ;
        endcase
    endfunction

    function automatic logic predict_inside(input logic [COORD_W-1:0] px,
                                            input logic [COORD_W-1:0] py,
                                            input logic [COORD_W-1:0] pz);
        longint dx, dy, dz, lx, ly;
        dx = longint'($signed(px)) - ctr_x;
        dy = longint'($signed(py)) - ctr_y;
        dz = longint'($signed(pz)) - ctr_z;
        lx = (dx * rot_cos - dy * rot_sin) >>> FRAC_SHIFT;
        ly = (dy * rot_cos + dx * rot_sin) >>> FRAC_SHIFT;
        return ((lx < 0 ? -lx : lx) <= ext_x) &&
               ((ly < 0 ? -ly : ly) <= ext_y) &&
               ((dz < 0 ? -dz : dz) <= ext_z);
    endfunction

    // Wait until every pending result is out, then let the pipeline settle
    task automatic wait_drained();
        while (inside_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [COORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_cfg(idx, data);
        @(posedge i_clk);
    endtask

    // Offer one point; record its expected flag once the transfer happens
    task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                              input logic [COORD_W-1:0] pz, input int want);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, pz, py, px};
        do @(posedge i_clk); while (!o_s_tready);
        if (want == USE_MODEL) inside_q.push_back(predict_inside(px, py, pz));
        else                   inside_q.push_back(want[0]);
    endtask

    // Random point: full range, box boundary, or near the box
    task automatic send_random_point();
        int     mode;
        longint hspan, zspan, ox, oy, oz;
        mode  = $urandom_range(0, 9);
        hspan = (ext_x > ext_y ? ext_x : ext_y) + 2;
        zspan = ext_z + 2;
        if (mode < 2) begin
            send_point(22'($urandom), 22'($urandom), 22'($urandom), USE_MODEL);
        end else begin
            if (mode == 2) begin
                ox = ext_x + $urandom_range(0, 1);
                oy = ext_y + $urandom_range(0, 1);
                oz = ext_z + $urandom_range(0, 1);
                if ($urandom_range(0, 1) == 1) ox = -ox;
                if ($urandom_range(0, 1) == 1) oy = -oy;
                if ($urandom_range(0, 1) == 1) oz = -oz;
            end else begin
                ox = longint'($urandom_range(0, 32'(2 * hspan))) - hspan;
                oy = longint'($urandom_range(0, 32'(2 * hspan))) - hspan;
                oz = longint'($urandom_range(0, 32'(2 * zspan))) - zspan;
            end
            send_point(22'(ctr_x + ox), 22'(ctr_y + oy), 22'(ctr_z + oz), USE_MODEL);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_off_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (recv_idling && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Compare each result transfer with the oldest expected flag
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (inside_q.size() == 0) begin
                $display("%0t: inside_res expected none actual %0d", $time, o_m_tdata[0]);
                mismatch_count++;
            end else begin
                if (o_m_tdata[0] !== inside_q[0]) begin
                    $display("%0t: inside_res expected %0d actual %0d",
                             $time, inside_q[0], o_m_tdata[0]);
                    mismatch_count++;
                end
                void'(inside_q.pop_front());
            end
        end
    end

    // Stimulus: reset, directed table, random phases
    initial begin
        ctr_x = 0; ctr_y = 0; ctr_z = 0;
        ext_x = 0; ext_y = 0; ext_z = 0;
        heading_q = '0;
        reload_rotation();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
                cfg_write(dir_rows[i].idx, dir_rows[i].a);
            end else begin
                send_point(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].want);
            end
        end
        i_s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            cfg_write(REG_CENTER_X, 22'($urandom));
            cfg_write(REG_CENTER_Y, 22'($urandom));
            cfg_write(REG_CENTER_Z, 22'($urandom));
            if (p == 0)      cfg_write(REG_BOX_HEADING, 22'd0);
            else if (p == 1) cfg_write(REG_BOX_HEADING, 22'd1024);
            else             cfg_write(REG_BOX_HEADING, 22'($urandom));
            // extents of random magnitude, top bit of the data randomly set
            cfg_write(REG_HALF_EXTENT_X, 22'($urandom_range(0, 1 << $urandom_range(0, 21)))
                      | (22'($urandom_range(0, 1)) << 21));
            cfg_write(REG_HALF_EXTENT_Y, 22'($urandom_range(0, 1 << $urandom_range(0, 21)))
                      | (22'($urandom_range(0, 1)) << 21));
            cfg_write(REG_HALF_EXTENT_Z, 22'($urandom_range(0, 1 << $urandom_range(0, 21)))
                      | (22'($urandom_range(0, 1)) << 21));
            if ($urandom_range(0, 1) == 1) cfg_write(REG_UNUSED, 22'($urandom));

            sender_gaps = (p != 3) && (p != PHASES - 1);
            recv_idling = (p != PHASES - 1);
            if (p == 3) hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) send_random_point();
            i_s_tvalid <= 1'b0;
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
